[hw/rtl/fsmep_pkg.sv]
// Shared constants, types and the sector ROM for the flash sector erase planner.
package fsmep_pkg;

  localparam int FIELD_W      = 24;
  localparam int ID_W         = 8;
  localparam int ROM_ENTRIES  = 14;
  localparam int ROM_IDX_W    = 4;
  localparam int MAP_ENTRIES  = 14;
  localparam int ADDR_BITS    = 24;

  // start addresses are reported modulo 2**ADDR_BITS
  localparam logic [FIELD_W-1:0] START_MASK = (ADDR_BITS >= FIELD_W) ? {FIELD_W{1'b1}} :
      FIELD_W'((64'd1 << ADDR_BITS) - 64'd1);

  localparam logic [1:0] CMD_RANGE  = 2'd0;
  localparam logic [1:0] CMD_NUMBER = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] KIND_ERASE   = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_LOOKUP  = 2'd2;

  typedef struct packed {
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] size;
    logic [ID_W-1:0]    number;
  } sector_t;

  typedef struct packed {
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] size;
    logic [ID_W-1:0]    number;
    logic               overlap;
    logic               holds;
  } entry_info_t;

  function automatic sector_t rom_entry(input logic [ROM_IDX_W-1:0] idx);
    sector_t e;
    e = '{start: '0, size: '0, number: '0};
    case (idx)
      4'd0:    e = '{start: 24'h080000, size: 24'h002000, number: 8'd0};
      4'd1:    e = '{start: 24'h082000, size: 24'h002000, number: 8'd1};
      4'd2:    e = '{start: 24'h084000, size: 24'h002000, number: 8'd2};
      4'd3:    e = '{start: 24'h086000, size: 24'h002000, number: 8'd3};
      4'd4:    e = '{start: 24'h088000, size: 24'h008000, number: 8'd4};
      4'd5:    e = '{start: 24'h090000, size: 24'h008000, number: 8'd5};
      4'd6:    e = '{start: 24'h098000, size: 24'h008000, number: 8'd6};
      4'd7:    e = '{start: 24'h0A0000, size: 24'h008000, number: 8'd7};
      4'd8:    e = '{start: 24'h0A8000, size: 24'h008000, number: 8'd8};
      4'd9:    e = '{start: 24'h0B0000, size: 24'h008000, number: 8'd9};
      4'd10:   e = '{start: 24'h0B8000, size: 24'h002000, number: 8'd10};
      4'd11:   e = '{start: 24'h0BA000, size: 24'h002000, number: 8'd11};
      4'd12:   e = '{start: 24'h0BC000, size: 24'h002000, number: 8'd12};
      4'd13:   e = '{start: 24'h0BE000, size: 24'h001FF0, number: 8'd13};
      default: e = '{start: '0, size: '0, number: '0};
    endcase
    return e;
  endfunction

endpackage

[hw/rtl/flash_sector_map_erase_planner_top.sv]
// Flash sector erase planner: top level sequencer and output register.
//
//   channel | signals                                          | dir
//   in      | in_valid, in_stall, command, word_addr,           | in
//           | length_words, sector_number                       |
//   out     | out_valid, out_stall, result_kind, sector_base,   | out
//           | sector_id, total_words, found, last               |
//
// One word in, then one table entry per cycle through the shared compare unit
// while no result waits. Range erase walks all entries, then one summary; erase
// by number first finds the sector; lookup ends on the hit or the last entry.
// in_stall is high from accept until the last result is loaded.
// out_stall holds the walk on the current entry while a result waits.
// rst is synchronous and returns the sequencer to idle, output empty.
module flash_sector_map_erase_planner_top
  import fsmep_pkg::*;
#(
  parameter int MAP_ENTRIES_P = MAP_ENTRIES
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [FIELD_W-1:0] word_addr,
  input  logic [FIELD_W-1:0] length_words,
  input  logic [ID_W-1:0]    sector_number,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         result_kind,
  output logic [FIELD_W-1:0] sector_base,
  output logic [ID_W-1:0]    sector_id,
  output logic [FIELD_W-1:0] total_words,
  output logic               found,
  output logic               last
);

  localparam int USED  = (MAP_ENTRIES_P > ROM_ENTRIES) ? ROM_ENTRIES : MAP_ENTRIES_P;
  localparam int IDX_W = (USED > 1) ? $clog2(USED) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(USED - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FIND = 5'b00010,
    S_WALK = 5'b00100,
    S_SUM  = 5'b01000,
    S_LOOK = 5'b10000
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   idx;
  logic [FIELD_W-1:0] lo;
  logic [FIELD_W:0]   hi;
  logic [ID_W-1:0]    num;
  logic               any;
  logic [FIELD_W-1:0] first;
  logic [FIELD_W-1:0] total;
  logic               slot_free;
  logic               out_load;
  entry_info_t        info;

  fsmep_entry_unit u_entry (
    .idx  (ROM_IDX_W'(idx)),
    .lo   (lo),
    .hi   (hi),
    .info (info)
  );

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;
  assign out_load  = slot_free && (((state == S_WALK) && info.overlap) || (state == S_SUM) ||
                     ((state == S_LOOK) && (info.holds || idx == LAST_IDX)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            idx   <= '0;
            any   <= 1'b0;
            total <= '0;
            first <= '0;
            num   <= sector_number;
            lo    <= word_addr;
            hi    <= {1'b0, word_addr} + {1'b0, length_words};
            case (command)
              CMD_RANGE:  state <= S_WALK;
              CMD_NUMBER: state <= S_FIND;
              CMD_LOOKUP: state <= S_LOOK;
              default:    state <= S_SUM;
            endcase
          end
        end
        S_FIND: begin
          if (info.number == num) begin
            lo    <= info.start;
            hi    <= {1'b0, info.start} + {1'b0, info.size};
            idx   <= '0;
            state <= S_WALK;
          end else if (idx == LAST_IDX) begin
            state <= S_SUM;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_WALK: begin
          if (slot_free) begin
            if (info.overlap) begin
              result_kind  <= KIND_ERASE;
              sector_base  <= info.start & START_MASK;
              sector_id    <= info.number;
              total_words  <= '0;
              found        <= 1'b1;
              last         <= 1'b0;
              if (!any) first <= info.start & START_MASK;
              any   <= 1'b1;
              total <= total + info.size;
            end
            if (idx == LAST_IDX) state <= S_SUM;
            else idx <= idx + 1'b1;
          end
        end
        S_SUM: begin
          if (slot_free) begin
            result_kind  <= KIND_SUMMARY;
            sector_base  <= first;
            sector_id    <= '0;
            total_words  <= total;
            found        <= any;
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_LOOK: begin
          if (slot_free) begin
            if (info.holds || idx == LAST_IDX) begin
              result_kind  <= KIND_LOOKUP;
              sector_base  <= info.holds ? (info.start & START_MASK) : '0;
              sector_id    <= info.holds ? info.number : '0;
              total_words  <= '0;
              found        <= info.holds;
              last         <= 1'b1;
              state        <= S_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/fsmep_entry_unit.sv]
// Shared table read and range compare unit, used once per walk step.
module fsmep_entry_unit
  import fsmep_pkg::*;
(
  input  logic [ROM_IDX_W-1:0] idx,
  input  logic [FIELD_W-1:0]   lo,
  input  logic [FIELD_W:0]     hi,
  output entry_info_t          info
);

  sector_t          ent;
  logic [FIELD_W:0] s_ext;
  logic [FIELD_W:0] e_ext;
  logic [FIELD_W:0] lo_ext;

  always_comb begin
    ent    = rom_entry(idx);
    s_ext  = {1'b0, ent.start};
    e_ext  = {1'b0, ent.start} + {1'b0, ent.size};
    lo_ext = {1'b0, lo};
    info.start   = ent.start;
    info.size    = ent.size;
    info.number  = ent.number;
    info.overlap = (e_ext > lo_ext) && (s_ext < hi);
    info.holds   = (lo_ext >= s_ext) && (lo_ext < e_ext);
  end

endmodule
